>>> rtl/core/oart_pkg.sv
// shared types and constants for the open address record table
`default_nettype none
package oart_pkg;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_SEARCH = 2'd0;
  localparam logic [1:0] REQ_PUT    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam int CAP_W    = 10;
  localparam int CAP_RST  = 512;
  localparam int IN_W     = 256;
  localparam int OUT_W    = 152;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  // controller states
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_SLOT_RD,
    S_SLOT_EV,
    S_REC_EV,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sweep;
    logic rd_slot;
    logic ev_slot;
    logic ev_rec;
    logic advance;
    logic commit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic slot_empty;
    logic rec_match;
    logic last_step;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/oart_ctrl.sv
// controller state machine for the record table
`default_nettype none
module oart_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic [1:0]      req_type,
  output logic                 in_tready,
  input  wire oart_pkg::stat_t st,
  output oart_pkg::cmd_t       cmd
);

  oart_pkg::state_t state_r, state_nxt;
  logic emit_r, emit_nxt;

  // state and clear-result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oart_pkg::S_SWEEP;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    case (state_r)
      oart_pkg::S_SWEEP: begin
        if (st.sweep_last) begin
          state_nxt = emit_r ? oart_pkg::S_FINISH : oart_pkg::S_IDLE;
        end
      end
      oart_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (req_type == oart_pkg::REQ_CLEAR) begin
            state_nxt = oart_pkg::S_SWEEP;
            emit_nxt  = 1'b1;
          end else begin
            state_nxt = oart_pkg::S_SLOT_RD;
          end
        end
      end
      oart_pkg::S_SLOT_RD: state_nxt = oart_pkg::S_SLOT_EV;
      oart_pkg::S_SLOT_EV: begin
        state_nxt = st.slot_empty ? oart_pkg::S_FINISH : oart_pkg::S_REC_EV;
      end
      oart_pkg::S_REC_EV: begin
        if (st.rec_match || st.last_step) begin
          state_nxt = oart_pkg::S_FINISH;
        end else begin
          state_nxt = oart_pkg::S_SLOT_RD;
        end
      end
      oart_pkg::S_FINISH: begin
        if (!st.out_busy) begin
          state_nxt = oart_pkg::S_IDLE;
          emit_nxt  = 1'b0;
        end
      end
      default: state_nxt = oart_pkg::S_SWEEP;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      oart_pkg::S_SWEEP:   cmd.sweep = 1'b1;
      oart_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      oart_pkg::S_SLOT_RD: cmd.rd_slot = 1'b1;
      oart_pkg::S_SLOT_EV: cmd.ev_slot = 1'b1;
      oart_pkg::S_REC_EV: begin
        cmd.ev_rec  = 1'b1;
        cmd.advance = !st.rec_match && !st.last_step;
      end
      oart_pkg::S_FINISH:  cmd.commit = !st.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/oart_dp.sv
// datapath: slot memory, record store, counters and result register
`default_nettype none
module oart_dp #(
  parameter int SLOTS       = 1024,
  parameter int MAX_RECORDS = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire oart_pkg::cmd_t               cmd,
  output oart_pkg::stat_t                   st,
  input  wire logic [1:0]                   in_req,
  input  wire logic [oart_pkg::IN_W-1:0]    in_word,
  input  wire logic [oart_pkg::CAP_W-1:0]   capacity,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [oart_pkg::OUT_W-1:0]        out_tdata
);

  localparam int SW  = $clog2(SLOTS);
  localparam int RW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int EW  = (CW > oart_pkg::CAP_W) ? CW : oart_pkg::CAP_W;

  // memories
  logic [CW-1:0]  slot_mem [SLOTS];
  logic [127:0]   name_mem [MAX_RECORDS];
  logic [127:0]   data_mem [MAX_RECORDS];
  logic           del_mem  [MAX_RECORDS];

  logic [CW-1:0]  slot_q;
  logic [127:0]   name_q, data_q;
  logic           del_q;

  // request and probe registers
  logic [1:0]     req_r;
  logic [127:0]   name_r, wdata_r;
  logic [SW-1:0]  pos_r;
  logic [SW:0]    step_r;
  logic [RW-1:0]  rec_r;
  logic           empty_r, hit_r;
  logic [SW-1:0]  sw_r;
  logic [CW-1:0]  cnt_r, cnt_nxt, del_r, del_nxt;
  logic           out_valid_r;
  logic [oart_pkg::OUT_W-1:0] out_r, out_nxt;

  logic [RW-1:0]  rd_idx;
  logic           match;
  logic [EW-1:0]  eff_cap, cap_e, max_e, cnt_e, cnt_ne;
  logic           do_update, do_append, do_remove, ovf;
  logic [oart_pkg::CAP_W-1:0] room, live;
  logic [SW:0]    pos_sum;

  assign rd_idx  = RW'(slot_q - CW'(1));
  assign match   = (name_q == name_r) && !del_q;
  assign pos_sum = (SW+1)'(pos_r) + step_r;

  // status toward the controller
  assign st.sweep_last = &sw_r;
  assign st.slot_empty = (slot_q == '0);
  assign st.rec_match  = match;
  assign st.last_step  = (step_r == (SW+1)'(SLOTS));
  assign st.out_busy   = out_valid_r && !out_tready;

  // effective capacity and commit decisions
  always_comb begin
    cap_e     = EW'(capacity);
    max_e     = EW'(MAX_RECORDS);
    eff_cap   = (cap_e > max_e) ? max_e : cap_e;
    cnt_e     = EW'(cnt_r);
    do_update = cmd.commit && req_r == oart_pkg::REQ_PUT && hit_r;
    ovf       = req_r == oart_pkg::REQ_PUT && !hit_r && (!empty_r || cnt_e >= eff_cap);
    do_append = cmd.commit && req_r == oart_pkg::REQ_PUT && !hit_r && !ovf;
    do_remove = cmd.commit && req_r == oart_pkg::REQ_REMOVE && hit_r;
    cnt_nxt   = cnt_r;
    del_nxt   = del_r;
    if (req_r == oart_pkg::REQ_CLEAR) begin
      cnt_nxt = '0;
      del_nxt = '0;
    end else begin
      if (do_append) cnt_nxt = cnt_r + CW'(1);
      if (do_remove) del_nxt = del_r + CW'(1);
    end
    cnt_ne = EW'(cnt_nxt);
    room   = (cnt_ne >= eff_cap) ? '0 : oart_pkg::CAP_W'(eff_cap - cnt_ne);
    live   = oart_pkg::CAP_W'(cnt_nxt - del_nxt);
  end

  // slot memory with clearing sweep
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      slot_mem[sw_r] <= '0;
    end else if (do_append) begin
      slot_mem[pos_r] <= cnt_r + CW'(1);
    end
    if (cmd.rd_slot) begin
      slot_q <= slot_mem[pos_r];
    end
  end

  // record store
  always_ff @(posedge clk) begin
    if (do_append) begin
      name_mem[RW'(cnt_r)] <= name_r;
      data_mem[RW'(cnt_r)] <= wdata_r;
      del_mem[RW'(cnt_r)]  <= 1'b0;
    end else begin
      if (do_update) data_mem[rec_r] <= wdata_r;
      if (do_remove) del_mem[rec_r]  <= 1'b1;
    end
    if (cmd.ev_slot) begin
      name_q <= name_mem[rd_idx];
      data_q <= data_mem[rd_idx];
      del_q  <= del_mem[rd_idx];
    end
  end

  // request and probe payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      name_r  <= {in_word[63:0], in_word[127:64]};
      wdata_r <= {in_word[191:128], in_word[255:192]};
      pos_r   <= in_word[SW+63:64];
      step_r  <= (SW+1)'(1);
    end else if (cmd.advance) begin
      pos_r  <= pos_sum[SW-1:0];
      step_r <= step_r + (SW+1)'(1);
    end
    if (cmd.ev_slot) rec_r <= rd_idx;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r        <= '0;
      cnt_r       <= '0;
      del_r       <= '0;
      empty_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) sw_r <= sw_r + SW'(1);
      if (cmd.load) begin
        empty_r <= 1'b0;
        hit_r   <= 1'b0;
      end
      if (cmd.ev_slot) empty_r <= (slot_q == '0);
      if (cmd.ev_rec)  hit_r   <= match;
      if (cmd.commit) begin
        cnt_r <= cnt_nxt;
        del_r <= del_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word contents
  always_comb begin
    out_nxt          = '0;
    out_nxt[0]       = (req_r != oart_pkg::REQ_CLEAR) && hit_r;
    out_nxt[64:1]    = (req_r == oart_pkg::REQ_SEARCH && hit_r) ? data_q[127:64] : '0;
    out_nxt[128:65]  = (req_r == oart_pkg::REQ_SEARCH && hit_r) ? data_q[63:0] : '0;
    out_nxt[138:129] = (req_r == oart_pkg::REQ_PUT) ? room : '0;
    out_nxt[139]     = ovf;
    out_nxt[149:140] = live;
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

>>> rtl/core/open_address_record_table.sv
// top level of the open address record table
//
//  port group | dir | handshake          | contents
//  in_        | in  | tvalid/tready      | tuser: req_type; tdata: names and metadata
//  out_       | out | tvalid/tready      | tdata: one result word per request
//  cfg_       | in  | psel/penable/pready| capacity register at byte address 0
//
// search, put and remove go from acceptance through the probes to the result, then to the next in_tready;
// a probe that reaches an empty slot ends after its slot check;
// each probe is a slot read, a slot check, then a record compare on registered memories.
// clear runs acceptance, a sweep with one slot zeroed a cycle, then the result.
// after reset the same clearing pass runs before in_tready rises.
// a stalled result word holds the following request in the finishing state; in_tready stays low.
`default_nettype none
module open_address_record_table #(
  parameter int SLOTS       = 1024,
  parameter int MAX_RECORDS = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // name_hi, name_lo, data_hi, data_lo from bit 0 up
  input  wire logic [oart_pkg::IN_W-1:0]         in_tdata,
  // req_type
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // found, out_data_hi, out_data_lo, room_left, status, live_count, zero pad
  output logic [oart_pkg::OUT_W-1:0]             out_tdata,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [oart_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire logic [oart_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [oart_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);

  oart_pkg::cmd_t  cmd;
  oart_pkg::stat_t st;
  logic [oart_pkg::CAP_W-1:0] cap_r;

  // capacity register, the only one; writes ignore the address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= oart_pkg::CAP_W'(oart_pkg::CAP_RST);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      cap_r <= cfg_pwdata[oart_pkg::CAP_W-1:0];
    end
  end

  // reads return capacity at address zero
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == '0) ? oart_pkg::CFG_DW'(cap_r) : '0;

  oart_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  oart_dp #(
    .SLOTS       (SLOTS),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_req     (in_tuser),
    .in_word    (in_tdata),
    .capacity   (cap_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/core/oart_checker.sv
// port-level checks for the record table and their binding
`default_nettype none
module oart_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [oart_pkg::OUT_W-1:0]    out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // an overflow is never also a hit
  a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[139]))
    else $error("overflow reported together with found");

  // metadata comes only with a hit
  a_data_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[128:1] != '0) |-> out_tdata[0])
    else $error("metadata without a hit");

  // metadata and room never appear in the same word
  a_room_or_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[138:129] != '0) |-> out_tdata[128:1] == '0)
    else $error("room and metadata in one word");

endmodule

bind open_address_record_table oart_checker u_oart_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> sim/open_address_record_table_test.sv
// self-checking testbench for the open address record table
`default_nettype none
module open_address_record_table_test;

  localparam int NSLOT         = 1024;
  localparam int NREC          = 512;
  localparam logic [oart_pkg::CFG_AW-1:0] ADDR_CAPACITY = '0;
  localparam int CYCLE_LIMIT   = 8000000;
  localparam int REPORT_MAX    = 10;
  localparam int LONG_HOLD     = 400;

  // one expected result word
  typedef struct packed {
    logic        found;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [9:0]  room_left;
    logic        status;
    logic [9:0]  live_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [oart_pkg::IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = oart_pkg::REQ_SEARCH;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [oart_pkg::OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [oart_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [oart_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [oart_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  open_address_record_table dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #5 clk = ~clk;

  // shadow copy of the table contents
  logic [9:0]  slot_map [NSLOT];
  logic [63:0] rec_name_hi [NREC];
  logic [63:0] rec_name_lo [NREC];
  logic [63:0] rec_data_hi [NREC];
  logic [63:0] rec_data_lo [NREC];
  logic        rec_deleted [NREC];
  int unsigned rec_total;
  int unsigned del_total;
  int unsigned capacity_reg;

  table_result_t pending_results [$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned overflows_seen;
  int unsigned clears_seen;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  int unsigned long_hold_req = 0;
  int unsigned long_hold_done = 0;
  bit          quiet;

  // pool of names, low bits of name_lo bunched to force long probe chains
  logic [63:0] pool_hi [48];
  logic [63:0] pool_lo [48];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // walk the quadratic chain; returns record number or 0, and the final slot
  function automatic int unsigned find_record(input logic [63:0] nhi, input logic [63:0] nlo,
                                              output int unsigned last_slot,
                                              output bit hit_empty);
    int unsigned pos;
    int unsigned rec;
    pos = nlo[9:0];
    hit_empty = 1'b0;
    last_slot = pos;
    for (int unsigned stp = 1; stp <= NSLOT; stp++) begin
      rec = slot_map[pos];
      last_slot = pos;
      if (rec == 0) begin
        hit_empty = 1'b1;
        return 0;
      end
      if (rec_name_hi[rec-1] == nhi && rec_name_lo[rec-1] == nlo && !rec_deleted[rec-1])
        return rec;
      pos = (pos + stp) % NSLOT;
    end
    return 0;
  endfunction

  function automatic int unsigned room_now();
    int unsigned c;
    c = (capacity_reg > NREC) ? NREC : capacity_reg;
    return (rec_total >= c) ? 0 : c - rec_total;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < NSLOT; i++) slot_map[i] = '0;
    for (int i = 0; i < NREC; i++) rec_deleted[i] = 1'b0;
    rec_total = 0;
    del_total = 0;
  endfunction

  // work out the result of one accepted request and update the shadow table
  function automatic table_result_t apply_request(input logic [1:0] req,
                                                  input logic [63:0] nhi, input logic [63:0] nlo,
                                                  input logic [63:0] dhi, input logic [63:0] dlo);
    table_result_t r;
    int unsigned rec;
    int unsigned slot;
    bit empty;
    r = '0;
    case (req)
      oart_pkg::REQ_SEARCH: begin
        rec = find_record(nhi, nlo, slot, empty);
        if (rec != 0) begin
          r.found = 1'b1;
          r.data_hi = rec_data_hi[rec-1];
          r.data_lo = rec_data_lo[rec-1];
        end
      end
      oart_pkg::REQ_PUT: begin
        rec = find_record(nhi, nlo, slot, empty);
        if (rec != 0) begin
          r.found = 1'b1;
          rec_data_hi[rec-1] = dhi;
          rec_data_lo[rec-1] = dlo;
        end else if (!empty || room_now() == 0) begin
          r.status = 1'b1;
        end else begin
          rec_name_hi[rec_total] = nhi;
          rec_name_lo[rec_total] = nlo;
          rec_data_hi[rec_total] = dhi;
          rec_data_lo[rec_total] = dlo;
          rec_deleted[rec_total] = 1'b0;
          rec_total++;
          slot_map[slot] = rec_total[9:0];
        end
        r.room_left = 10'(room_now());
      end
      oart_pkg::REQ_REMOVE: begin
        rec = find_record(nhi, nlo, slot, empty);
        if (rec != 0) begin
          rec_deleted[rec-1] = 1'b1;
          del_total++;
          r.found = 1'b1;
        end
      end
      default: clear_shadow();
    endcase
    r.live_count = 10'(rec_total - del_total);
    return r;
  endfunction

  // offer one word and wait for the handshake
  task automatic send_word(input logic [1:0] req, input logic [63:0] nhi, input logic [63:0] nlo,
                           input logic [63:0] dhi, input logic [63:0] dlo);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {dlo, dhi, nlo, nhi};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(req, nhi, nlo, dhi, dlo));
    words_sent++;
    if (req == oart_pkg::REQ_CLEAR) clears_seen++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned value);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_CAPACITY;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    capacity_reg = value & 10'h3FF;
  endtask

  // result checker
  always @(posedge clk) begin
    table_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found      = out_tdata[0];
      got.data_hi    = out_tdata[64:1];
      got.data_lo    = out_tdata[128:65];
      got.room_left  = out_tdata[138:129];
      got.status     = out_tdata[139];
      got.live_count = out_tdata[149:140];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result word %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.found) hits_seen++;
        if (got.status) overflows_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch at result %0d: expected %p got %p", results_seen, want, got);
        end
      end
    end
  end

  // receiver stalls, with a long hold-off counted here when a test asks for one
  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (long_hold_req != long_hold_done) begin
      out_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= long_hold_done + 1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (quiet || r < 70) begin
      out_tready <= 1'b1;
    end else if (r < 97) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b0;
      hold_left <= $urandom_range(10, 40);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL open_address_record_table");
      $finish;
    end
  end

  // extremes, collisions, remove and re-put, clear
  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_word(oart_pkg::REQ_PUT, ones, ones, ones, ones);
    send_word(oart_pkg::REQ_SEARCH, ones, ones, '0, '0);
    send_word(oart_pkg::REQ_PUT, ones, ones, '0, '0);
    send_word(oart_pkg::REQ_SEARCH, ones, ones, ones, ones);
    send_word(oart_pkg::REQ_SEARCH, '0, '0, '0, '0);
    send_word(oart_pkg::REQ_PUT, '0, '0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    // same home slot as the all-ones name
    send_word(oart_pkg::REQ_PUT, 64'h5, 64'h3FF, 64'hAAAA_5555_AAAA_5555,
              64'h5555_AAAA_5555_AAAA);
    send_word(oart_pkg::REQ_PUT, 64'h6, 64'h3FF, 64'h1, 64'h2);
    send_word(oart_pkg::REQ_SEARCH, 64'h6, 64'h3FF, '0, '0);
    send_word(oart_pkg::REQ_REMOVE, ones, ones, '0, '0);
    send_word(oart_pkg::REQ_SEARCH, ones, ones, '0, '0);
    send_word(oart_pkg::REQ_REMOVE, ones, ones, '0, '0);
    // deleted name comes back as a fresh record
    send_word(oart_pkg::REQ_PUT, ones, ones, 64'h77, 64'h88);
    send_word(oart_pkg::REQ_SEARCH, ones, ones, '0, '0);
    send_word(oart_pkg::REQ_SEARCH, 64'h5, 64'h3FF, '0, '0);
    send_word(oart_pkg::REQ_CLEAR, ones, ones, ones, ones);
    send_word(oart_pkg::REQ_SEARCH, 64'h6, 64'h3FF, '0, '0);
    send_word(oart_pkg::REQ_PUT, 64'h6, 64'h3FF, 64'h3, 64'h4);
  endtask

  // overflow at capacity, lowered capacity, zero and oversize capacity
  task automatic test_capacity();
    send_word(oart_pkg::REQ_CLEAR, '0, '0, '0, '0);
    write_capacity(2);
    send_word(oart_pkg::REQ_PUT, 64'h10, 64'h10, 64'h1, 64'h1);
    send_word(oart_pkg::REQ_PUT, 64'h11, 64'h11, 64'h2, 64'h2);
    send_word(oart_pkg::REQ_PUT, 64'h12, 64'h12, 64'h3, 64'h3);
    send_word(oart_pkg::REQ_PUT, 64'h10, 64'h10, 64'h9, 64'h9);
    write_capacity(1);
    send_word(oart_pkg::REQ_PUT, 64'h11, 64'h11, 64'h5, 64'h5);
    send_word(oart_pkg::REQ_SEARCH, 64'h11, 64'h11, '0, '0);
    write_capacity(0);
    send_word(oart_pkg::REQ_CLEAR, '0, '0, '0, '0);
    send_word(oart_pkg::REQ_PUT, 64'h13, 64'h13, 64'h6, 64'h6);
    write_capacity(1023);
    send_word(oart_pkg::REQ_PUT, 64'h13, 64'h13, 64'h7, 64'h7);
    send_word(oart_pkg::REQ_SEARCH, 64'h13, 64'h13, '0, '0);
    drain();
  endtask

  // mostly traffic on a bunched name pool, plus random noise names
  task automatic test_random(input int unsigned count);
    int unsigned k, r;
    logic [1:0] req;
    logic [63:0] nhi, nlo;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) req = oart_pkg::REQ_PUT;
      else if (r < 75) req = oart_pkg::REQ_SEARCH;
      else if (r < 99) req = oart_pkg::REQ_REMOVE;
      else req = oart_pkg::REQ_CLEAR;
      k = $urandom_range(0, 47);
      if ($urandom_range(0, 9) == 0) begin
        nhi = rand64();
        nlo = rand64();
      end else begin
        nhi = pool_hi[k];
        nlo = pool_lo[k];
      end
      send_word(req, nhi, nlo, rand64(), rand64());
    end
  endtask

  // long receiver hold-off while the sender keeps offering back to back
  task automatic test_backpressure();
    quiet = 1'b1;
    long_hold_req++;
    for (int unsigned n = 0; n < 40; n++)
      send_word(n[0] ? oart_pkg::REQ_SEARCH : oart_pkg::REQ_PUT, pool_hi[n % 48],
                pool_lo[n % 48], rand64(), rand64());
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned caps [5];
    mismatches = 0; words_sent = 0; results_seen = 0; hits_seen = 0;
    overflows_seen = 0; clears_seen = 0; quiet = 1'b0;
    capacity_reg = oart_pkg::CAP_RST;
    clear_shadow();
    for (int i = 0; i < 48; i++) begin
      pool_hi[i] = rand64();
      pool_lo[i] = rand64();
      if (i % 2 == 0) pool_lo[i][9:0] = 10'(($urandom_range(0, 3)) * 255);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_capacity();
    caps = '{512, 40, 1023, 8, 200};
    for (int p = 0; p < 5; p++) begin
      write_capacity(caps[p]);
      test_random(230);
    end
    write_capacity($urandom_range(1, 512));
    test_backpressure();
    test_random(40);

    drain();
    repeat (50) @(posedge clk);
    $display("%0d requests sent, %0d results checked: %0d hits, %0d overflows, %0d clears",
             words_sent, results_seen, hits_seen, overflows_seen, clears_seen);
    $display("capacities 0 to 1023 exercised with collisions, removes and a long stall");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS open_address_record_table");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("FAIL open_address_record_table");
    end
    $finish;
  end

endmodule
`default_nettype wire
